// ----- design/hsl_pkg.sv -----
// Shared types and constants for the HSL to RGB converter.
// Depends on nothing; every other file of the block imports it.
package hsl_pkg;

	// Input fractions arrive with 16 fraction bits, so 1.0 is 65536.
	localparam int              IN_W        = 17;
	localparam int              IN_FRAC     = 16;
	localparam logic [IN_W-1:0] IN_FULL     = 17'h10000;

	// Output channel range and the scale applied before rounding.
	localparam int              LEVEL_W     = 8;
	localparam logic [7:0]      LEVEL_MAX   = 8'd255;
	localparam int              LEVEL_SCALE = 255;

	// The queue between the front and back parts.
	localparam int              Q_DEPTH     = 4;
	localparam int              Q_AW        = 2;
	localparam int              Q_CW        = 3;

	// Hue sector, i.e. which sixth of the color wheel the hue lies in.
	typedef enum logic [2:0] {
		SEC_RY = 3'd0,
		SEC_YG = 3'd1,
		SEC_GC = 3'd2,
		SEC_CB = 3'd3,
		SEC_BM = 3'd4,
		SEC_MR = 3'd5
	} sector_t;

endpackage

// ----- design/hsl_to_rgb_converter_top.sv -----
// Top level of the HSL to RGB converter: front classifier, queue and back
// arithmetic pipe. Depends on hsl_pkg, hsl_front, hsl_fifo and hsl_back.
//
//   channel   direction   handshake             word
//   input     in          in_valid / in_stall   hue_frac, sat_frac, light_frac
//   output    out         out_valid / out_stall red_level, green_level, blue_level
//
// One word is accepted per clock while in_stall is low, and one result
// word leaves per clock while out_stall is low. An accepted word passes
// one front stage, the queue, then four back stages (two multiplies,
// placement, scaling). There is no state between words and no clearing
// pass; reset only empties the pipe and the queue. A stall on the output
// freezes the back pipe, the four-entry queue absorbs the front's words,
// and in_stall rises once the queue is full and the front stage is held.
module hsl_to_rgb_converter_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [hsl_pkg::IN_W-1:0]    hue_frac,
	input  logic [hsl_pkg::IN_W-1:0]    sat_frac,
	input  logic [hsl_pkg::IN_W-1:0]    light_frac,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [hsl_pkg::LEVEL_W-1:0] red_level,
	output logic [hsl_pkg::LEVEL_W-1:0] green_level,
	output logic [hsl_pkg::LEVEL_W-1:0] blue_level
);
	import hsl_pkg::*;

	localparam int W  = FRAC_BITS + 1;
	// Queue word: sector, chroma span, saturation, hue weight, lightness.
	localparam int QW = 3 + 4 * W;

	sector_t       f_sector, b_sector;
	logic [W-1:0]  f_span, f_sat, f_weight, f_light;
	logic          q_push, q_full, q_pop, q_empty;
	logic [QW-1:0] q_wdata, q_rdata;

	hsl_front #(
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.hue_frac    (hue_frac),
		.sat_frac    (sat_frac),
		.light_frac  (light_frac),
		.q_push      (q_push),
		.q_full      (q_full),
		.sector      (f_sector),
		.chroma_span (f_span),
		.sat         (f_sat),
		.hue_weight  (f_weight),
		.light       (f_light)
	);

	assign q_wdata = {f_sector, f_span, f_sat, f_weight, f_light};

	hsl_fifo #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty)
	);

	assign b_sector = sector_t'(q_rdata[QW-1 -: 3]);

	hsl_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.sector      (b_sector),
		.chroma_span (q_rdata[4*W-1 -: W]),
		.sat         (q_rdata[3*W-1 -: W]),
		.hue_weight  (q_rdata[2*W-1 -: W]),
		.light       (q_rdata[W-1:0]),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.red_level   (red_level),
		.green_level (green_level),
		.blue_level  (blue_level)
	);

endmodule

// ----- design/hsl_front.sv -----
// Front part of the HSL to RGB converter: accepts input words, clamps and
// scales them, and classifies the hue. Depends on hsl_pkg.
module hsl_front #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [hsl_pkg::IN_W-1:0]      hue_frac,
	input  logic [hsl_pkg::IN_W-1:0]      sat_frac,
	input  logic [hsl_pkg::IN_W-1:0]      light_frac,
	output logic                          q_push,
	input  logic                          q_full,
	output hsl_pkg::sector_t              sector,
	output logic [FRAC_BITS:0]            chroma_span,
	output logic [FRAC_BITS:0]            sat,
	output logic [FRAC_BITS:0]            hue_weight,
	output logic [FRAC_BITS:0]            light
);
	import hsl_pkg::*;

	localparam int W = FRAC_BITS + 1;
	localparam logic [W-1:0] ONE_FX = W'(1) << FRAC_BITS;

	logic [IN_W-1:0] hue_cl, sat_cl, light_cl;
	logic [W-1:0]    hue_cv, sat_cv, light_cv;
	logic            accept;
	logic            valid_s1;
	logic [W-1:0]    hue_s1, sat_s1, light_s1;

	logic [W:0]      light2, one_ext, light_dist;
	logic [W+1:0]    h6;
	logic [2:0]      sector_raw;
	logic [W-1:0]    h_mod, h_dist;

	// Fractions above 1.0 are clamped to 1.0.
	assign hue_cl   = (hue_frac   > IN_FULL) ? IN_FULL : hue_frac;
	assign sat_cl   = (sat_frac   > IN_FULL) ? IN_FULL : sat_frac;
	assign light_cl = (light_frac > IN_FULL) ? IN_FULL : light_frac;

	if (FRAC_BITS >= IN_FRAC) begin : g_widen
		assign hue_cv   = W'(hue_cl)   << (FRAC_BITS - IN_FRAC);
		assign sat_cv   = W'(sat_cl)   << (FRAC_BITS - IN_FRAC);
		assign light_cv = W'(light_cl) << (FRAC_BITS - IN_FRAC);
	end else begin : g_narrow
		logic [IN_W-1:0] hue_sh, sat_sh, light_sh;
		assign hue_sh   = hue_cl   >> (IN_FRAC - FRAC_BITS);
		assign sat_sh   = sat_cl   >> (IN_FRAC - FRAC_BITS);
		assign light_sh = light_cl >> (IN_FRAC - FRAC_BITS);
		assign hue_cv   = hue_sh[W-1:0];
		assign sat_cv   = sat_sh[W-1:0];
		assign light_cv = light_sh[W-1:0];
	end

	// The stage holds its word until the queue has room.
	assign in_stall = valid_s1 & q_full;
	assign accept   = in_valid & ~in_stall;
	assign q_push   = valid_s1 & ~q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept | (valid_s1 & q_full);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hue_s1   <= hue_cv;
			sat_s1   <= sat_cv;
			light_s1 <= light_cv;
		end
	end

	// Chroma span 1 - |2L - 1| and hue weight 1 - |(6H mod 2) - 1|.
	always_comb begin
		light2     = {light_s1, 1'b0};
		one_ext    = {1'b0, ONE_FX};
		light_dist = (light2 >= one_ext) ? (light2 - one_ext) : (one_ext - light2);
		h6         = {hue_s1, 2'b00} + {1'b0, hue_s1, 1'b0};
		sector_raw = h6[W+1:FRAC_BITS];
		h_mod      = h6[FRAC_BITS:0];
		h_dist     = (h_mod >= ONE_FX) ? (h_mod - ONE_FX) : (ONE_FX - h_mod);
		// A hue of exactly 1.0 lands in the last sector.
		sector     = (sector_raw > SEC_MR) ? SEC_MR : sector_t'(sector_raw);
		chroma_span = ONE_FX - light_dist[W-1:0];
		hue_weight  = ONE_FX - h_dist;
	end

	assign sat   = sat_s1;
	assign light = light_s1;

	a_sector_clamped : assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (sector <= SEC_MR))
		else $error("front: hue sector out of range");

endmodule

// ----- design/hsl_fifo.sv -----
// Short register queue between the front and back parts of the converter.
// Depends on hsl_pkg for its depth.
module hsl_fifo #(
	parameter int WIDTH = 71
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);
	import hsl_pkg::*;

	logic [WIDTH-1:0] entry_q [Q_DEPTH];
	logic [Q_AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [Q_CW-1:0]  count_q;
	logic             push_ok, pop_ok;

	assign full     = (count_q == Q_CW'(Q_DEPTH));
	assign empty    = (count_q == '0);
	assign push_ok  = push & ~full;
	assign pop_ok   = pop & ~empty;
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + Q_CW'(push_ok) - Q_CW'(pop_ok);
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	a_count_bound : assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= Q_CW'(Q_DEPTH))
		else $error("queue: occupancy above depth");

	a_count_track : assert property (@(posedge clk) disable iff (!arst_n)
		(push_ok && !pop_ok) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue: occupancy did not follow a push");

endmodule

// ----- design/hsl_back.sv -----
// Back part of the HSL to RGB converter: chroma and X multiplies, sector
// placement, scaling to eight-bit levels. Depends on hsl_pkg.
module hsl_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_empty,
	output logic                           q_pop,
	input  hsl_pkg::sector_t               sector,
	input  logic [FRAC_BITS:0]             chroma_span,
	input  logic [FRAC_BITS:0]             sat,
	input  logic [FRAC_BITS:0]             hue_weight,
	input  logic [FRAC_BITS:0]             light,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [hsl_pkg::LEVEL_W-1:0]    red_level,
	output logic [hsl_pkg::LEVEL_W-1:0]    green_level,
	output logic [hsl_pkg::LEVEL_W-1:0]    blue_level
);
	import hsl_pkg::*;

	localparam int W  = FRAC_BITS + 1;
	localparam int PW = W + 10;
	localparam logic [W-1:0]  ONE_FX = W'(1) << FRAC_BITS;
	localparam logic [PW-1:0] HALF   = PW'(1) << (FRAC_BITS - 1);

	logic            adv;
	logic            valid_s1, valid_s2, valid_s3, valid_s4;
	logic [2*W-1:0]  c_prod, x_prod;
	logic [W-1:0]    c_s1, hw_s1, light_s1;
	sector_t         sec_s1, sec_s2, sec_s3;
	logic [W-1:0]    c_s2, x_s2, m_s2;
	logic [W-1:0]    r_pick, g_pick, b_pick;
	logic [W:0]      red_s3, green_s3, blue_s3;
	logic [7:0]      red_s4, green_s4, blue_s4;

	function automatic logic [7:0] to_level(input logic [W:0] v);
		logic [PW-1:0] p;
		logic [9:0]    q;
		p = PW'(v) * PW'(LEVEL_SCALE) + HALF;
		q = p[FRAC_BITS +: 10];
		return (q > 10'(LEVEL_MAX)) ? LEVEL_MAX : q[7:0];
	endfunction

	// The whole pipe moves together unless a finished word is held.
	assign adv       = ~(valid_s4 & out_stall);
	assign q_pop     = adv & ~q_empty;
	assign c_prod    = (2*W)'(chroma_span) * (2*W)'(sat);
	assign x_prod    = (2*W)'(c_s1) * (2*W)'(hw_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= ~q_empty;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_comb begin
		unique case (sec_s2)
			SEC_RY: begin r_pick = c_s2; g_pick = x_s2; b_pick = '0;   end
			SEC_YG: begin r_pick = x_s2; g_pick = c_s2; b_pick = '0;   end
			SEC_GC: begin r_pick = '0;   g_pick = c_s2; b_pick = x_s2; end
			SEC_CB: begin r_pick = '0;   g_pick = x_s2; b_pick = c_s2; end
			SEC_BM: begin r_pick = x_s2; g_pick = '0;   b_pick = c_s2; end
			default: begin r_pick = c_s2; g_pick = '0;  b_pick = x_s2; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// Stage 1: chroma C = span * S.
			c_s1     <= c_prod[2*FRAC_BITS -: W];
			hw_s1    <= hue_weight;
			light_s1 <= light;
			sec_s1   <= sector;
			// Stage 2: X = C * weight and offset m = L - C/2.
			x_s2     <= x_prod[2*FRAC_BITS -: W];
			m_s2     <= light_s1 - (c_s1 >> 1);
			c_s2     <= c_s1;
			sec_s2   <= sec_s1;
			// Stage 3: place C and X by sector and add the offset.
			red_s3   <= {1'b0, r_pick} + {1'b0, m_s2};
			green_s3 <= {1'b0, g_pick} + {1'b0, m_s2};
			blue_s3  <= {1'b0, b_pick} + {1'b0, m_s2};
			sec_s3   <= sec_s2;
			// Stage 4: scale, round half up and saturate.
			red_s4   <= to_level(red_s3);
			green_s4 <= to_level(green_s3);
			blue_s4  <= to_level(blue_s3);
		end
	end

	assign out_valid   = valid_s4;
	assign red_level   = red_s4;
	assign green_level = green_s4;
	assign blue_level  = blue_s4;

	a_chroma_le_one : assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (c_s1 <= ONE_FX))
		else $error("back: chroma above one");

	a_x_le_chroma : assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (x_s2 <= c_s2) && (m_s2 <= ONE_FX))
		else $error("back: X above chroma or offset above one");

	a_sector_kept : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && adv) |-> (sec_s3 <= SEC_MR))
		else $error("back: sector code lost in pipe");

endmodule

// ----- bench/hsl_to_rgb_converter_top_tb.sv -----
// Self-checking bench for hsl_to_rgb_converter_top: a directed table, then random pixels.
// Each result word is compared against its pinned table levels or an in-bench fixed-point HSL to RGB predictor.
// Depends on hsl_pkg and the converter RTL only.
`timescale 1ns / 1ps

module hsl_to_rgb_converter_top_tb;
	import hsl_pkg::*;

	// The internal precision that the DUT is built with. The predictor follows it.
	localparam int          FB          = 16;
	localparam logic [63:0] ONE         = 64'd1 << FB;
	localparam int          RANDOM_WORDS = 650;
	// This many clocks in a row with no word moving on either side means a hang.
	// The slowest correct stretch is the long output hold plus a few gaps.
	localparam int          QUIET_LIMIT = 4000;

	typedef struct packed {
		logic [LEVEL_W-1:0] red;
		logic [LEVEL_W-1:0] green;
		logic [LEVEL_W-1:0] blue;
	} rgb_t;

	// One row of the directed table. When pinned is set, the typed levels are
	// the expectation. Otherwise the predictor supplies it.
	typedef struct packed {
		logic [IN_W-1:0]    hue;
		logic [IN_W-1:0]    sat;
		logic [IN_W-1:0]    light;
		logic               pinned;
		logic [LEVEL_W-1:0] red;
		logic [LEVEL_W-1:0] green;
		logic [LEVEL_W-1:0] blue;
	} color_case_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [IN_W-1:0]     hue_frac;
	logic [IN_W-1:0]     sat_frac;
	logic [IN_W-1:0]     light_frac;
	logic                out_valid;
	logic                out_stall;
	logic [LEVEL_W-1:0]  red_level;
	logic [LEVEL_W-1:0]  green_level;
	logic [LEVEL_W-1:0]  blue_level;

	rgb_t pending_rgb[$];   // Expected colors, oldest first.
	rgb_t next_expected;    // The color that belongs to the word now offered.
	int   mismatch_count = 0;
	int   quiet_cycles   = 0;
	bit   tx_steady      = 0;   // When set, the sender offers words back to back.

	// The directed rows cover black, white and mid gray; pure primaries at
	// hue 0 and at hue exactly 1.0, which lands in the last sector; inputs
	// above 1.0, which are clamped; and both sides of each sector boundary but 0.5.
	color_case_t directed_cases [0:21] = '{
		'{17'd0,       17'd0,       17'd0,       1'b1, 8'd0,   8'd0,   8'd0  },
		'{17'd0,       17'd0,       17'd65536,   1'b1, 8'd255, 8'd255, 8'd255},
		'{17'd0,       17'd0,       17'd32768,   1'b1, 8'd128, 8'd128, 8'd128},
		'{17'd0,       17'd65536,   17'd32768,   1'b1, 8'd255, 8'd0,   8'd0  },
		'{17'd65536,   17'd65536,   17'd32768,   1'b1, 8'd255, 8'd0,   8'd0  },
		'{17'd32768,   17'd65536,   17'd32768,   1'b1, 8'd0,   8'd255, 8'd255},
		'{17'h1FFFF,   17'h1FFFF,   17'h1FFFF,   1'b1, 8'd255, 8'd255, 8'd255},
		'{17'h1FFFF,   17'd65536,   17'd32768,   1'b1, 8'd255, 8'd0,   8'd0  },
		'{17'd0,       17'h1FFFF,   17'd0,       1'b1, 8'd0,   8'd0,   8'd0  },
		'{17'h0FFFF,   17'h0FFFF,   17'h0FFFF,   1'b0, 8'd0,   8'd0,   8'd0  },
		'{17'd10922,   17'd65536,   17'd32768,   1'b0, 8'd0,   8'd0,   8'd0  },
		'{17'd10923,   17'd65536,   17'd32768,   1'b0, 8'd0,   8'd0,   8'd0  },
		'{17'd21845,   17'd65536,   17'd32768,   1'b0, 8'd0,   8'd0,   8'd0  },
		'{17'd21846,   17'd65536,   17'd32768,   1'b0, 8'd0,   8'd0,   8'd0  },
		'{17'd43690,   17'd65536,   17'd32768,   1'b0, 8'd0,   8'd0,   8'd0  },
		'{17'd43691,   17'd65536,   17'd49152,   1'b0, 8'd0,   8'd0,   8'd0  },
		'{17'd54613,   17'd65536,   17'd32768,   1'b0, 8'd0,   8'd0,   8'd0  },
		'{17'd54614,   17'd32768,   17'd16384,   1'b0, 8'd0,   8'd0,   8'd0  },
		'{17'd65535,   17'd65536,   17'd32768,   1'b0, 8'd0,   8'd0,   8'd0  },
		'{17'd10000,   17'd65536,   17'd65535,   1'b0, 8'd0,   8'd0,   8'd0  },
		'{17'd12345,   17'd1,       17'd1,       1'b0, 8'd0,   8'd0,   8'd0  },
		'{17'd65536,   17'd10000,   17'd40000,   1'b0, 8'd0,   8'd0,   8'd0  }
	};

	hsl_to_rgb_converter_top #(
		.FRAC_BITS(FB)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.hue_frac   (hue_frac),
		.sat_frac   (sat_frac),
		.light_frac (light_frac),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.red_level  (red_level),
		.green_level(green_level),
		.blue_level (blue_level)
	);

	// Clamp an input fraction to 1.0 and move it to the internal precision.
	function automatic logic [63:0] clamp_frac(logic [IN_W-1:0] raw);
		logic [63:0] v;
		v = (raw > IN_FULL) ? 64'(IN_FULL) : 64'(raw);
		return v << (FB - IN_FRAC);
	endfunction

	// Scale a 0..1.0 channel to 0..255, rounding half up, then saturate.
	function automatic logic [LEVEL_W-1:0] scale_level(logic [63:0] v);
		logic [63:0] q;
		q = (v * LEVEL_SCALE + (ONE >> 1)) >> FB;
		return (q > 64'(LEVEL_MAX)) ? LEVEL_MAX : q[LEVEL_W-1:0];
	endfunction

	// Fixed-point HSL to RGB. All terms are unsigned with FB fraction bits,
	// and every product is truncated back to FB bits.
	function automatic rgb_t predict_rgb(logic [IN_W-1:0] h, logic [IN_W-1:0] s,
			logic [IN_W-1:0] l);
		logic [63:0] hue, sat, lig, light_dist, chroma, h6, sec_idx, hm, tri_dist;
		logic [63:0] xval, base;
		logic [63:0] r, g, b;
		sector_t     sec;
		rgb_t        res;
		hue = clamp_frac(h);
		sat = clamp_frac(s);
		lig = clamp_frac(l);
		light_dist = ((lig << 1) >= ONE) ? (lig << 1) - ONE : ONE - (lig << 1);
		chroma = ((ONE - light_dist) * sat) >> FB;
		h6 = 6 * hue;
		sec_idx = h6 >> FB;
		// Hue of exactly 1.0 would give sector six; it belongs to the last one.
		if (sec_idx > 5) begin
			sec_idx = 5;
		end
		sec = sector_t'(sec_idx[2:0]);
		hm = h6 & ((ONE << 1) - 1);
		tri_dist = (hm >= ONE) ? hm - ONE : ONE - hm;
		xval = (chroma * (ONE - tri_dist)) >> FB;
		base = lig - (chroma >> 1);
		case (sec)
			SEC_RY: begin r = chroma; g = xval;   b = 0;      end
			SEC_YG: begin r = xval;   g = chroma; b = 0;      end
			SEC_GC: begin r = 0;      g = chroma; b = xval;   end
			SEC_CB: begin r = 0;      g = xval;   b = chroma; end
			SEC_BM: begin r = xval;   g = 0;      b = chroma; end
			default: begin r = chroma; g = 0;     b = xval;   end
		endcase
		res.red   = scale_level(r + base);
		res.green = scale_level(g + base);
		res.blue  = scale_level(b + base);
		return res;
	endfunction

	// A random fraction, weighted toward the ends of the range. The clamped
	// region above 1.0 is drawn too, so that every input bit toggles.
	function automatic logic [IN_W-1:0] draw_frac();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return IN_FULL;
			2: return IN_W'($urandom_range(65537, 131071));
			3: return IN_W'($urandom_range(65536 - 64, 65536));
			default: return IN_W'($urandom_range(0, 65536));
		endcase
	endfunction

	// Offer one word after a random gap and return at the edge that takes it.
	// Valid is lowered only when there is a gap, so back-to-back words keep
	// it high with no second assignment in the same step.
	task automatic send_word(input logic [IN_W-1:0] h, input logic [IN_W-1:0] s,
			input logic [IN_W-1:0] l, input rgb_t want);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 7);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		hue_frac      <= h;
		sat_frac      <= s;
		light_frac    <= l;
		next_expected = want;
		in_valid      <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Sender: reset, then the directed table, then random pixels.
	initial begin
		rgb_t            want;
		logic [IN_W-1:0] h, s, l;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		hue_frac   = '0;
		sat_frac   = '0;
		light_frac = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < $size(directed_cases); i++) begin
			if (directed_cases[i].pinned) begin
				want = '{directed_cases[i].red, directed_cases[i].green,
					directed_cases[i].blue};
			end else begin
				want = predict_rgb(directed_cases[i].hue, directed_cases[i].sat,
					directed_cases[i].light);
			end
			send_word(directed_cases[i].hue, directed_cases[i].sat,
				directed_cases[i].light, want);
		end

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			// Now and then switch to a stretch of back-to-back words.
			if (n % 40 == 0) begin
				tx_steady = ($urandom_range(0, 3) == 0);
			end
			h = draw_frac();
			s = draw_frac();
			l = draw_frac();
			// Some hues sit right on a sector boundary or one step past it.
			if ($urandom_range(0, 7) == 0) begin
				h = IN_W'(($urandom_range(1, 6) * 65536) / 6 + $urandom_range(0, 1));
			end
			send_word(h, s, l, predict_rgb(h, s, l));
		end
		@(negedge clk);
		in_valid <= 1'b0;

		// Drain, then give any stray word time to show up.
		while (pending_rgb.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && pending_rgb.size() == 0) begin
			$display("PASS hsl_to_rgb_converter_top");
		end else begin
			$display("FAIL hsl_to_rgb_converter_top");
		end
		$finish;
	end

	// Receiver: a random hold before each result word, with steady stretches,
	// and once a long hold so that the pipe and its queue fill and the input
	// side has to stall.
	initial begin
		int hold;
		int taken;
		bit rx_steady;
		bit long_done;
		taken     = 0;
		rx_steady = 0;
		long_done = 0;
		out_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (taken % 32 == 0) begin
				rx_steady = ($urandom_range(0, 3) == 0);
			end
			hold = rx_steady ? 0 : $urandom_range(0, 7);
			if (!long_done && taken == 200) begin
				hold      = 120;
				long_done = 1;
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			taken++;
			@(negedge clk);
		end
	end

	// Scoreboard and watchdog. The output side is checked before the input
	// side queues its expectation, so the order within an edge is fixed.
	always @(posedge clk) begin
		rgb_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_rgb.size() == 0) begin
					$error("result word with no expected color pending: %0d %0d %0d",
						red_level, green_level, blue_level);
					mismatch_count++;
				end else begin
					want = pending_rgb.pop_front();
					if (red_level !== want.red) begin
						$error("red_level: expected %0d, got %0d", want.red, red_level);
						mismatch_count++;
					end
					if (green_level !== want.green) begin
						$error("green_level: expected %0d, got %0d", want.green,
							green_level);
						mismatch_count++;
					end
					if (blue_level !== want.blue) begin
						$error("blue_level: expected %0d, got %0d", want.blue, blue_level);
						mismatch_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				pending_rgb.push_back(next_expected);
			end
			if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL hsl_to_rgb_converter_top");
				$finish;
			end
		end
	end

endmodule
